// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Needs i_clk and i_rst_n in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/dtt_pkg.sv =====
// Types, codes and helpers of the deadline timer table.
// No dependencies.
package dtt_pkg;

    localparam logic [2:0] K_ADD    = 3'd0;
    localparam logic [2:0] K_REMOVE = 3'd1;
    localparam logic [2:0] K_TOGGLE = 3'd2;
    localparam logic [2:0] K_CHGINT = 3'd3;
    localparam logic [2:0] K_DISP   = 3'd4;
    localparam logic [2:0] K_REMALL = 3'd5;
    localparam logic [2:0] K_WAIT   = 3'd6;

    localparam logic [62:0] DL_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam int MAX_RESULTS = 16;
    localparam int RW = 5;
    localparam int RA = 4;

    typedef struct packed {
        logic [31:0] id;
        logic [62:0] period;
        logic [62:0] deadline;
        logic        rep;
    } t_entry;

    function automatic logic [62:0] sat_add(logic [62:0] a, logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[63] ? DL_MAX : s[62:0];
    endfunction

endpackage

// ===== rtl/dtt_ram.sv =====
// Timer entry memory: one write port, one read port, registered read data.
// Depends on dtt_pkg.
module dtt_ram
    import dtt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== rtl/deadline_timer_table.sv =====
// Deadline timer table: sorted timer list in one memory, sequenced by one FSM.
// Remove all, kind 7 and a full add answer without a table scan; a wait query reads
// the head entry. Other commands scan the table entry by entry for find/shift and
// run an insertion sort pass, paced by the single memory read port. One item at a
// time. Reset empties the table and clears the id counter; memory contents are
// not cleared.
module deadline_timer_table
    import dtt_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_kind,
    input  logic [31:0]        i_target_id,
    input  logic [62:0]        i_period,
    input  logic               i_enable,
    input  logic               i_repeating,
    input  logic [62:0]        i_now_time,
    input  logic signed [63:0] i_wait_limit,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_status,
    output logic [31:0]        o_result_id,
    output logic               o_fired,
    output logic signed [63:0] o_wait_time,
    output logic               o_last
);

`include "assert_macros.svh"

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_FIND_RD  = 15'h0002,
        S_FIND_CHK = 15'h0004,
        S_SH_RD    = 15'h0008,
        S_SH_WR    = 15'h0010,
        S_SORT_I   = 15'h0020,
        S_SORT_H   = 15'h0040,
        S_SORT_RD  = 15'h0080,
        S_SORT_CMP = 15'h0100,
        S_D_RD     = 15'h0200,
        S_D_CHK    = 15'h0400,
        S_D_REM    = 15'h0800,
        S_W_CHK    = 15'h1000,
        S_EMIT1    = 15'h2000,
        S_EMITN    = 15'h4000
    } t_state;

    t_state r_state, n_state;
    logic [2:0]  r_kind, n_kind;
    logic [31:0] r_target, n_target;
    logic [62:0] r_period, n_period;
    logic        r_enable, n_enable;
    logic [62:0] r_now, n_now;
    logic [63:0] r_limit, n_limit;
    logic [CW-1:0] r_count, n_count;
    logic [31:0] r_idc, n_idc;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    t_entry      r_hold, n_hold;
    logic [RW-1:0] r_n, n_n;
    logic [RW-1:0] r_k, n_k;
    logic [31:0] r_ids [MAX_RESULTS];
    logic        r_reps [MAX_RESULTS];
    logic        r_p_status, n_p_status;
    logic [31:0] r_p_id, n_p_id;
    logic [63:0] r_p_wait, n_p_wait;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata, rd;
    logic          rec_we;
    logic          out_free, out_load;
    logic          ld_fired, ld_last;
    logic [31:0]   ld_id;
    logic          ld_status;
    logic [63:0]   ld_wait;
    logic [31:0]   idc_inc;
    logic [63:0]   w_sum;
    logic          accept;

    logic               r_ovalid;
    logic               r_ostatus;
    logic [31:0]        r_oid;
    logic               r_ofired;
    logic [63:0]        r_owait;
    logic               r_olast;

    dtt_ram #(
        .DEPTH (TIMER_SLOTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign idc_inc  = r_idc + 32'd1;
    assign w_sum    = {1'b0, r_now} + r_limit;

    always_comb begin
        n_state = r_state;  n_kind = r_kind;  n_target = r_target;
        n_period = r_period;  n_enable = r_enable;  n_now = r_now;
        n_limit = r_limit;  n_count = r_count;  n_idc = r_idc;
        n_i = r_i;  n_j = r_j;  n_hold = r_hold;  n_n = r_n;  n_k = r_k;
        n_p_status = r_p_status;  n_p_id = r_p_id;  n_p_wait = r_p_wait;
        mem_we = 1'b0;  mem_waddr = r_i[AW-1:0];  mem_wdata = rd;
        mem_raddr = r_i[AW-1:0];
        rec_we = 1'b0;
        out_load = 1'b0;  ld_status = 1'b0;  ld_id = '0;  ld_fired = 1'b0;
        ld_wait = '0;  ld_last = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind = i_kind;  n_target = i_target_id;  n_period = i_period;
                    n_enable = i_enable;  n_now = i_now_time;  n_limit = i_wait_limit;
                    n_p_status = 1'b0;  n_p_id = '0;  n_p_wait = '0;
                    n_state = S_EMIT1;
                    case (i_kind)
                        K_ADD: begin
                            if (r_count == CW'(TIMER_SLOTS)) begin
                                n_p_status = 1'b1;
                            end else begin
                                n_idc = (idc_inc == 32'd0) ? 32'd1 : idc_inc;
                                mem_we = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata.id = n_idc;
                                mem_wdata.period = i_period;
                                mem_wdata.deadline = i_enable ?
                                    sat_add(i_now_time, i_period) : DL_MAX;
                                mem_wdata.rep = i_repeating;
                                n_count = r_count + CW'(1);
                                n_i = CW'(1);
                                n_state = S_SORT_I;
                            end
                        end
                        K_REMOVE, K_TOGGLE, K_CHGINT: begin
                            n_i = '0;
                            n_state = S_FIND_RD;
                        end
                        K_DISP: begin
                            n_i = '0;
                            n_n = '0;
                            if (r_count != '0) begin
                                n_state = S_D_RD;
                            end
                        end
                        K_REMALL: begin
                            n_count = '0;
                        end
                        K_WAIT: begin
                            n_p_wait = i_wait_limit;
                            if (r_count != '0) begin
                                mem_raddr = '0;
                                n_state = S_W_CHK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIND_RD: begin
                if (r_i < r_count) begin
                    n_state = S_FIND_CHK;
                end else if (r_kind == K_DISP) begin
                    n_k = r_k + RW'(1);
                    n_state = S_D_REM;
                end else begin
                    n_state = S_EMIT1;
                end
            end
            S_FIND_CHK: begin
                if (rd.id == r_target) begin
                    case (r_kind)
                        K_TOGGLE: begin
                            mem_we = 1'b1;
                            mem_wdata.deadline = r_enable ?
                                sat_add(r_now, rd.period) : DL_MAX;
                            n_i = CW'(1);
                            n_state = S_SORT_I;
                        end
                        K_CHGINT: begin
                            mem_we = 1'b1;
                            mem_wdata.period = r_period;
                            n_state = S_EMIT1;
                        end
                        default: begin
                            n_state = S_SH_RD;
                        end
                    endcase
                end else begin
                    n_i = r_i + CW'(1);
                    n_state = S_FIND_RD;
                end
            end
            S_SH_RD: begin
                if (({1'b0, r_i} + (CW+1)'(1)) < {1'b0, r_count}) begin
                    mem_raddr = AW'(r_i + CW'(1));
                    n_state = S_SH_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    if (r_kind == K_DISP) begin
                        n_k = r_k + RW'(1);
                        n_state = S_D_REM;
                    end else begin
                        n_state = S_EMIT1;
                    end
                end
            end
            S_SH_WR: begin
                mem_we = 1'b1;
                n_i = r_i + CW'(1);
                n_state = S_SH_RD;
            end
            S_SORT_I: begin
                if (r_i >= r_count) begin
                    if (r_kind == K_DISP) begin
                        n_k = '0;
                        n_state = S_EMITN;
                    end else begin
                        if (r_kind == K_ADD) begin
                            n_p_id = r_idc;
                        end
                        n_state = S_EMIT1;
                    end
                end else begin
                    n_state = S_SORT_H;
                end
            end
            S_SORT_H: begin
                n_hold = rd;
                n_j = r_i;
                n_state = S_SORT_RD;
            end
            S_SORT_RD: begin
                if (r_j == '0) begin
                    mem_we = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = r_hold;
                    n_i = r_i + CW'(1);
                    n_state = S_SORT_I;
                end else begin
                    mem_raddr = AW'(r_j - CW'(1));
                    n_state = S_SORT_CMP;
                end
            end
            S_SORT_CMP: begin
                mem_we = 1'b1;
                mem_waddr = r_j[AW-1:0];
                if (rd.deadline > r_hold.deadline) begin
                    mem_wdata = rd;
                    n_j = r_j - CW'(1);
                    n_state = S_SORT_RD;
                end else begin
                    mem_wdata = r_hold;
                    n_i = r_i + CW'(1);
                    n_state = S_SORT_I;
                end
            end
            S_D_RD: begin
                if (r_i < r_count && r_n != RW'(MAX_RESULTS)) begin
                    n_state = S_D_CHK;
                end else begin
                    n_k = '0;
                    n_state = (r_n == '0) ? S_EMIT1 : S_D_REM;
                end
            end
            S_D_CHK: begin
                if (rd.deadline <= r_now && !(r_i == '0 && rd.deadline == DL_MAX)) begin
                    mem_we = 1'b1;
                    mem_wdata.deadline = sat_add(r_now, rd.period);
                    rec_we = 1'b1;
                    n_n = r_n + RW'(1);
                    n_i = r_i + CW'(1);
                    n_state = S_D_RD;
                end else begin
                    n_k = '0;
                    n_state = (r_n == '0) ? S_EMIT1 : S_D_REM;
                end
            end
            S_D_REM: begin
                if (r_k == r_n) begin
                    n_i = CW'(1);
                    n_state = S_SORT_I;
                end else if (r_reps[r_k[RA-1:0]]) begin
                    n_k = r_k + RW'(1);
                end else begin
                    n_target = r_ids[r_k[RA-1:0]];
                    n_i = '0;
                    n_state = S_FIND_RD;
                end
            end
            S_W_CHK: begin
                if (rd.deadline != DL_MAX) begin
                    if (r_limit[63] || w_sum > {1'b0, rd.deadline}) begin
                        n_p_wait = (rd.deadline <= r_now) ? 64'd0 :
                            {1'b0, rd.deadline - r_now};
                    end
                end
                n_state = S_EMIT1;
            end
            S_EMIT1: begin
                ld_status = r_p_status;
                ld_id = r_p_id;
                ld_wait = r_p_wait;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMITN: begin
                ld_id = r_ids[r_k[RA-1:0]];
                ld_fired = 1'b1;
                ld_last = (r_k + RW'(1) == r_n);
                if (out_free) begin
                    out_load = 1'b1;
                    n_k = r_k + RW'(1);
                    if (ld_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idc   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idc   <= n_idc;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;  r_target <= n_target;  r_period <= n_period;
        r_enable <= n_enable;  r_now <= n_now;  r_limit <= n_limit;
        r_i <= n_i;  r_j <= n_j;  r_hold <= n_hold;  r_n <= n_n;  r_k <= n_k;
        r_p_status <= n_p_status;  r_p_id <= n_p_id;  r_p_wait <= n_p_wait;
        if (rec_we) begin
            r_ids[r_n[RA-1:0]]  <= rd.id;
            r_reps[r_n[RA-1:0]] <= rd.rep;
        end
        if (out_load) begin
            r_ostatus <= ld_status;
            r_oid     <= ld_id;
            r_ofired  <= ld_fired;
            r_owait   <= ld_wait;
            r_olast   <= ld_last;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_result_id = r_oid;
    assign o_fired     = r_ofired;
    assign o_wait_time = r_owait;
    assign o_last      = r_olast;

    `ASSERT_IMPL(a_count_max, 1'b1, r_count <= CW'(TIMER_SLOTS))
    `ASSERT_IMPL(a_fired_ok, o_valid && o_fired, !o_status)
    `ASSERT_NEXT(a_remall, accept && i_kind == K_REMALL, r_count == '0)

endmodule
